// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and defaults for the sorted priority queue
// Default sizes and the per-cycle command that every cell of the chain sees.
// ----------------------------------------------------------------------------
package spq_pkg;

    // default sizes
    localparam int DEPTH_DEF        = 128;
    localparam int KEY_BITS_DEF     = 8;
    localparam int PAYLOAD_BITS_DEF = 8;

    // request kinds carried on s_tuser
    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_POP    = 1'b1
    } spq_req_t;

    // command broadcast to every cell in a cycle
    typedef struct packed {
        logic shift_in;   // insert: open a slot and shift the tail right
        logic shift_out;  // pop: shift everything left by one
    } spq_cmd_t;

endpackage

// ===== hdl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one key/payload pair, compares it with the broadcast key and takes
// the new entry, its left neighbor's entry or its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int KEY_BITS     = spq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
    parameter int CNT_BITS     = 8,
    parameter int INDEX        = 0
) (
    input  logic                           aclk,
    input  spq_pkg::spq_cmd_t              cmd,
    input  logic        [CNT_BITS-1:0]     count,
    input  logic signed [KEY_BITS-1:0]     new_key,
    input  logic signed [PAYLOAD_BITS-1:0] new_payload,
    input  logic signed [KEY_BITS-1:0]     prev_key,
    input  logic signed [PAYLOAD_BITS-1:0] prev_payload,
    input  logic                           prev_after,
    input  logic signed [KEY_BITS-1:0]     next_key,
    input  logic signed [PAYLOAD_BITS-1:0] next_payload,
    output logic signed [KEY_BITS-1:0]     key,
    output logic signed [PAYLOAD_BITS-1:0] payload,
    output logic                           after
);

    logic signed [KEY_BITS-1:0]     key_reg, key_next;
    logic signed [PAYLOAD_BITS-1:0] payload_reg, payload_next;
    logic                           occupied;

    // slot holds a live entry that stays ahead of the new key
    assign occupied = CNT_BITS'(INDEX) < count;
    assign after    = occupied && (key_reg <= new_key);

    // slot select
    always_comb begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (cmd.shift_in) begin
            if (!after) begin
                if (prev_after) begin
                    key_next     = new_key;
                    payload_next = new_payload;
                end else begin
                    key_next     = prev_key;
                    payload_next = prev_payload;
                end
            end
        end else if (cmd.shift_out) begin
            key_next     = next_key;
            payload_next = next_payload;
        end
    end

    // payload storage, no reset needed
    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;

endmodule

// ===== hdl/sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: bounded priority queue, smallest key first
// A chain of DEPTH cells kept in ascending key order; equal keys leave in
// arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on the s_ channel: s_tuser selects insert (0) or pop (1),
//   s_tdata carries key and payload for an insert. Every request returns one
//   beat on the m_ channel: popped payload and entry count in m_tdata,
//   pop_valid and error_flag in m_tuser.
//   An insert into a full queue is dropped with error_flag set; a pop from
//   an empty queue returns zero payload with error_flag set.
//   The result beat is registered at the accepting edge. Throughput is one
//   request per cycle while the receiver keeps up, set by the cell chain,
//   which shifts all slots in parallel in the cycle a request is accepted.
//   When the receiver stalls, the result holds in the output register and
//   s_tready drops until it is taken.
//   Reset empties the queue (count to zero) and clears the output valid;
//   slot contents are not cleared, only the first count slots are ever used.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
    parameter int DEPTH        = spq_pkg::DEPTH_DEF,
    parameter int KEY_BITS     = spq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
    parameter int CNT_BITS     = $clog2(DEPTH + 1),
    parameter int S_TDATA_W    = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
    parameter int M_TDATA_W    = ((PAYLOAD_BITS + CNT_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // new_key, new_payload
    input  logic                 s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // pop_payload, entry_count
    output logic [1:0]           m_tuser    // pop_valid, error_flag
);

    logic signed [KEY_BITS-1:0]     new_key;
    logic signed [PAYLOAD_BITS-1:0] new_payload;
    logic                           is_insert;
    logic                           accept;
    logic                           full, empty;
    spq_pkg::spq_cmd_t              cmd;

    logic [CNT_BITS-1:0]     count_reg, count_next;
    logic                    m_valid_reg, m_valid_next;
    logic [PAYLOAD_BITS-1:0] pop_payload_reg, pop_payload_next;
    logic                    pop_valid_reg, pop_valid_next;
    logic                    error_reg, error_next;

    logic signed [KEY_BITS-1:0]     cell_key     [DEPTH];
    logic signed [PAYLOAD_BITS-1:0] cell_payload [DEPTH];
    logic                           cell_after   [DEPTH];

    // input unpacking
    assign new_key     = s_tdata[KEY_BITS-1:0];
    assign new_payload = s_tdata[KEY_BITS+PAYLOAD_BITS-1:KEY_BITS];
    assign is_insert   = (spq_pkg::spq_req_t'(s_tuser) == spq_pkg::REQ_INSERT);

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign empty    = (count_reg == '0);

    // chain command
    assign cmd.shift_in  = accept && is_insert && !full;
    assign cmd.shift_out = accept && !is_insert && !empty;

    // cell chain
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [KEY_BITS-1:0]     prev_key, next_key;
        logic signed [PAYLOAD_BITS-1:0] prev_payload, next_payload;
        logic                           prev_after;

        if (i == 0) begin : g_head
            assign prev_key     = new_key;
            assign prev_payload = new_payload;
            assign prev_after   = 1'b1;
        end else begin : g_body
            assign prev_key     = cell_key[i-1];
            assign prev_payload = cell_payload[i-1];
            assign prev_after   = cell_after[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign next_key     = cell_key[i];
            assign next_payload = cell_payload[i];
        end else begin : g_mid
            assign next_key     = cell_key[i+1];
            assign next_payload = cell_payload[i+1];
        end

        spq_cell #(
            .KEY_BITS     (KEY_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS),
            .CNT_BITS     (CNT_BITS),
            .INDEX        (i)
        ) u_cell (
            .aclk         (aclk),
            .cmd          (cmd),
            .count        (count_reg),
            .new_key      (new_key),
            .new_payload  (new_payload),
            .prev_key     (prev_key),
            .prev_payload (prev_payload),
            .prev_after   (prev_after),
            .next_key     (next_key),
            .next_payload (next_payload),
            .key          (cell_key[i]),
            .payload      (cell_payload[i]),
            .after        (cell_after[i])
        );
    end

    // count and result beat
    always_comb begin
        count_next       = count_reg;
        m_valid_next     = m_valid_reg;
        pop_payload_next = pop_payload_reg;
        pop_valid_next   = pop_valid_reg;
        error_next       = error_reg;
        if (cmd.shift_in) begin
            count_next = count_reg + CNT_BITS'(1);
        end else if (cmd.shift_out) begin
            count_next = count_reg - CNT_BITS'(1);
        end
        if (accept) begin
            m_valid_next     = 1'b1;
            pop_payload_next = cmd.shift_out ? cell_payload[0] : '0;
            pop_valid_next   = cmd.shift_out;
            error_next       = is_insert ? full : empty;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pop_payload_reg <= pop_payload_next;
        pop_valid_reg   <= pop_valid_next;
        error_reg       <= error_next;
    end

    // entry_count reflects the count after the request held in the beat
    logic [CNT_BITS-1:0] count_out_reg, count_out_next;
    assign count_out_next = accept ? count_next : count_out_reg;

    always_ff @(posedge aclk) begin
        count_out_reg <= count_out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({count_out_reg, pop_payload_reg});
    assign m_tuser  = {error_reg, pop_valid_reg};

endmodule

// ===== hdl/spq_check.sv =====
// ----------------------------------------------------------------------------
// spq_check: port-level checks for the sorted priority queue
// Watches the top-level channels and flags result beats that break the
// queue's rules; bound onto every instance of the top level.
// ----------------------------------------------------------------------------
module spq_check #(
    parameter int DEPTH        = spq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
    parameter int CNT_BITS     = $clog2(DEPTH + 1),
    parameter int M_TDATA_W    = ((PAYLOAD_BITS + CNT_BITS + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [1:0]           m_tuser
);

    logic [PAYLOAD_BITS-1:0] pop_payload;
    logic [CNT_BITS-1:0]     entry_count;

    assign pop_payload = m_tdata[PAYLOAD_BITS-1:0];
    assign entry_count = m_tdata[PAYLOAD_BITS+CNT_BITS-1:PAYLOAD_BITS];

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // no new request while an untaken result waits
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !m_tvalid || m_tready)
        else $error("request accepted over a waiting result");

    // a pop that returned an entry is never an error
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("pop_valid and error_flag both set");

    // payload is zero unless a pop returned an entry
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> pop_payload == '0)
        else $error("nonzero payload without a popped entry");

    // count stays within the queue size
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> entry_count <= CNT_BITS'(DEPTH))
        else $error("entry count beyond queue depth");

endmodule

bind sorted_priority_queue_unit spq_check #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .CNT_BITS     (CNT_BITS),
    .M_TDATA_W    (M_TDATA_W)
) u_spq_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
